FILE: hdl/roos_pkg.sv
`timescale 1ns / 1ps

package roos_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int SUM_W   = 13;
  // Reciprocal width: one bit above the sum plus one spare
  localparam int RECIP_W = SUM_W + 2;
  // Signed width for window bounds (center +/- up to 256)
  localparam int SPAN_W  = COORD_W + 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
  localparam logic [PIX_W-1:0]   OFFSET_MAX = '1;
  localparam logic [COORD_W-1:0] CENTER_RST = 10'd512;

  typedef enum logic [0:0] {
    REG_WINDOW_CENTER_X = 1'b0,
    REG_WINDOW_CENTER_Y = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             in_window;
  } out_item_t;

endpackage

FILE: hdl/row_reference_offset_subtract.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------
// in       | input     | in_valid / in_stall  | in_data  (pixel_in, column, row)
// out      | output    | out_valid / out_stall| out_data (pixel_out, in_window)
// cfg      | input     | APB psel/penable     | window_center_x @0, window_center_y @4
//
// One pixel per clock sustained while out_stall stays low; a transfer passes
// through the input register and then the result register.
// Longest path: 13-bit saturating add, reciprocal multiply, clamped subtract.
// Synchronous active-low reset clears valids, strip sum and row offset, and
// sets both window centers to 512.
// A stalled result holds; the input register accepts when empty or draining.

module row_reference_offset_subtract #(
  parameter int REF_COLUMNS = 30,
  parameter int HALF_WINDOW = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  roos_pkg::in_item_t                  in_data,

  output logic                                out_valid,
  input  logic                                out_stall,
  output roos_pkg::out_item_t                 out_data,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [roos_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [roos_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [roos_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int PIX_W   = roos_pkg::PIX_W;
  localparam int COORD_W = roos_pkg::COORD_W;
  localparam int SUM_W   = roos_pkg::SUM_W;
  localparam int RECIP_W = roos_pkg::RECIP_W;
  localparam int SPAN_W  = roos_pkg::SPAN_W;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // floor(s / REF_COLUMNS) == (s * ceil(2^K / REF_COLUMNS)) >> K, exact for all
  // 13-bit s when K = 13 + ceil(log2(REF_COLUMNS)).
  localparam int RECIP_SHIFT = SUM_W + $clog2(REF_COLUMNS);
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'(((2 ** RECIP_SHIFT) + REF_COLUMNS - 1) / REF_COLUMNS);

  localparam logic [COORD_W-1:0] REF_COLS_C = COORD_W'(REF_COLUMNS);
  localparam logic [COORD_W-1:0] REF_LAST_C = COORD_W'(REF_COLUMNS - 1);
  localparam logic signed [SPAN_W-1:0] HALF_C = SPAN_W'(HALF_WINDOW);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] win_cx_r, win_cx_nxt;
  logic [COORD_W-1:0] win_cy_r, win_cy_nxt;
  logic               cfg_wr;
  roos_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // Word addressing: paddr[2] picks the register
  assign cfg_idx = roos_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    win_cx_nxt = win_cx_r;
    win_cy_nxt = win_cy_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        roos_pkg::REG_WINDOW_CENTER_X: win_cx_nxt = pwdata[COORD_W-1:0];
        roos_pkg::REG_WINDOW_CENTER_Y: win_cy_nxt = pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      roos_pkg::REG_WINDOW_CENTER_X:
        prdata = {{(roos_pkg::CFG_DATA_W - COORD_W){1'b0}}, win_cx_r};
      roos_pkg::REG_WINDOW_CENTER_Y:
        prdata = {{(roos_pkg::CFG_DATA_W - COORD_W){1'b0}}, win_cy_r};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds result register
  // ---------------------------------------------------------------------------
  roos_pkg::in_item_t  in_r;
  roos_pkg::out_item_t out_r, out_nxt;
  logic                in_vld_r, in_vld_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                in_xfer;
  logic                advance;

  // Move the held pixel on whenever the result slot is empty or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Strip sum and row offset
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]  reference_sum_r, reference_sum_nxt;
  logic [PIX_W-1:0]  row_offset_r, row_offset_nxt;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_cur;
  logic [PROD_W-1:0] mean_prod;
  logic [SUM_W-1:0]  mean_q;
  logic [PIX_W-1:0]  mean_sat;
  logic [PIX_W-1:0]  offset_eff;
  logic              in_strip;
  logic              strip_last;

  assign in_strip   = in_r.column < REF_COLS_C;
  assign strip_last = in_r.column == REF_LAST_C;

  always_comb begin
    sum_wide = {1'b0, reference_sum_r} + {{(SUM_W + 1 - PIX_W){1'b0}}, in_r.pixel_in};
    if (in_r.column == '0) begin
      sum_cur = {{(SUM_W - PIX_W){1'b0}}, in_r.pixel_in};
    end else if (sum_wide[SUM_W]) begin
      sum_cur = roos_pkg::SUM_MAX;
    end else begin
      sum_cur = sum_wide[SUM_W-1:0];
    end
  end

  assign mean_prod = {{RECIP_W{1'b0}}, sum_cur} * {{SUM_W{1'b0}}, RECIP_C};
  assign mean_q    = SUM_W'(mean_prod >> RECIP_SHIFT);
  assign mean_sat  = (mean_q > {{(SUM_W - PIX_W){1'b0}}, roos_pkg::OFFSET_MAX})
                   ? roos_pkg::OFFSET_MAX : mean_q[PIX_W-1:0];

  // A window pixel on the last strip column already sees its own row's mean
  assign offset_eff = (in_strip && strip_last) ? mean_sat : row_offset_r;

  always_comb begin
    reference_sum_nxt = reference_sum_r;
    row_offset_nxt    = row_offset_r;
    if (advance && in_strip) begin
      reference_sum_nxt = sum_cur;
      if (strip_last) begin
        row_offset_nxt = mean_sat;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window test and clamped subtract
  // ---------------------------------------------------------------------------
  logic signed [SPAN_W-1:0] x_lo, x_hi, y_lo, y_hi, col_s, row_s;
  logic                     win;

  always_comb begin
    x_lo  = $signed({2'b00, win_cx_r}) - HALF_C;
    x_hi  = $signed({2'b00, win_cx_r}) + HALF_C - SPAN_W'(1);
    y_lo  = $signed({2'b00, win_cy_r}) - HALF_C;
    y_hi  = $signed({2'b00, win_cy_r}) + HALF_C - SPAN_W'(1);
    col_s = $signed({2'b00, in_r.column});
    row_s = $signed({2'b00, in_r.row});
    win   = (col_s >= x_lo) && (col_s <= x_hi) && (row_s >= y_lo) && (row_s <= y_hi);
  end

  always_comb begin
    out_nxt = out_r;
    if (advance) begin
      out_nxt.in_window = win;
      if (!win) begin
        out_nxt.pixel_out = in_r.pixel_in;
      end else if (in_r.pixel_in < offset_eff) begin
        out_nxt.pixel_out = '0;
      end else begin
        out_nxt.pixel_out = in_r.pixel_in - offset_eff;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      reference_sum_r <= '0;
      row_offset_r    <= '0;
      win_cx_r        <= roos_pkg::CENTER_RST;
      win_cy_r        <= roos_pkg::CENTER_RST;
    end else begin
      in_vld_r        <= in_vld_nxt;
      out_vld_r       <= out_vld_nxt;
      reference_sum_r <= reference_sum_nxt;
      row_offset_r    <= row_offset_nxt;
      win_cx_r        <= win_cx_nxt;
      win_cy_r        <= win_cy_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_offset_only_on_strip_end: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && in_strip && strip_last) |=> $stable(row_offset_r))
    else $error("row offset changed outside the last strip column");

  a_never_brightens: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_r.pixel_out <= $past(in_r.pixel_in)))
    else $error("corrected pixel exceeds raw pixel");

  a_outside_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !win) |=> (out_r.pixel_out == $past(in_r.pixel_in)) && !out_r.in_window)
    else $error("pixel outside window was altered");

endmodule
